@@ rtl/bpp_pkg.sv @@
package bpp_pkg;

   localparam int BusWidth   = 15;
   localparam int ShuntWidth = 16;
   localparam int TapWidth   = 14;
   localparam int GainWidth  = 18;
   localparam int QWidth     = TapWidth + GainWidth;
   localparam int MvWidth    = 16;
   localparam int CsrWidth   = 18;
   localparam int CsrIdxWidth = 3;

   localparam logic [QWidth-1:0] BalanceQ = QWidth'(4150) << 16;

   typedef enum logic [1:0] {
      CAUSE_NONE        = 2'd0,
      CAUSE_OVERCURRENT = 2'd1,
      CAUSE_OVERVOLTAGE = 2'd2,
      CAUSE_UNDERVOLT   = 2'd3
   } cause_type;

   typedef enum logic [CsrIdxWidth-1:0] {
      REG_OVERCURRENT = 3'd0,
      REG_OVERVOLTAGE = 3'd1,
      REG_UVLO_LOAD   = 3'd2,
      REG_UVLO_IDLE   = 3'd3,
      REG_DISCHARGE   = 3'd4,
      REG_TAP1_GAIN   = 3'd5,
      REG_TAP2_GAIN   = 3'd6,
      REG_TAP3_GAIN   = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic signed [ShuntWidth-1:0] overcurrent_limit;
      logic [BusWidth-1:0]          overvoltage_limit;
      logic [BusWidth-1:0]          uvlo_load_limit;
      logic [BusWidth-1:0]          uvlo_idle_limit;
      logic signed [ShuntWidth-1:0] discharge_limit;
   } limits_type;

   typedef struct packed {
      cause_type cause;
      logic      discharging;
   } trip_type;

endpackage

@@ rtl/bpp_trip_eval.sv @@
module bpp_trip_eval
   import bpp_pkg::*;
(
   input  limits_type                   limits,
   input  logic [BusWidth-1:0]          bus_code,
   input  logic signed [ShuntWidth-1:0] shunt_code,
   output trip_type                     trip
);

   logic                dis;
   logic [BusWidth-1:0] uvlo_limit;

   assign dis        = shunt_code > limits.discharge_limit;
   assign uvlo_limit = dis ? limits.uvlo_load_limit : limits.uvlo_idle_limit;

   always_comb begin
      trip.discharging = dis;
      if (shunt_code > limits.overcurrent_limit) begin
         trip.cause = CAUSE_OVERCURRENT;
      end else if (bus_code > limits.overvoltage_limit) begin
         trip.cause = CAUSE_OVERVOLTAGE;
      end else if (bus_code < uvlo_limit) begin
         trip.cause = CAUSE_UNDERVOLT;
      end else begin
         trip.cause = CAUSE_NONE;
      end
   end

endmodule

@@ rtl/battery_pack_protection_unit.sv @@
// Path: an input transfer passes through the multiply, cell difference, threshold and
// output register stages before its result is valid and can transfer.
// Throughput: one measurement set per cycle when the result is not stalled; a stalled
// result holds the full stages behind it, while a stage behind an empty one still advances.
// Reset: clears all stage valid bits and loads the limit and gain registers
// with their default values.
module battery_pack_protection_unit
   import bpp_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [BusWidth-1:0]           req_bus_code,
   input  logic signed [ShuntWidth-1:0]  req_shunt_code,
   input  logic [TapWidth-1:0]           req_tap1_sum,
   input  logic [TapWidth-1:0]           req_tap2_sum,
   input  logic [TapWidth-1:0]           req_tap3_sum,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_relay_closed,
   output logic [1:0]                    rsp_trip_cause,
   output logic                          rsp_discharging,
   output logic                          rsp_balance_one,
   output logic                          rsp_balance_two,
   output logic                          rsp_balance_three,
   output logic [MvWidth-1:0]            rsp_cell1_mv,
   output logic [MvWidth-1:0]            rsp_cell2_mv,
   output logic [MvWidth-1:0]            rsp_cell3_mv,
   input  logic                          csr_we,
   input  logic [CsrIdxWidth-1:0]        csr_index,
   input  logic [CsrWidth-1:0]           csr_wdata
);

   limits_type           limits_ff;
   logic [GainWidth-1:0] gain1_ff, gain2_ff, gain3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         limits_ff.overcurrent_limit <= ShuntWidth'(32000);
         limits_ff.overvoltage_limit <= BusWidth'(10160);
         limits_ff.uvlo_load_limit   <= BusWidth'(6800);
         limits_ff.uvlo_idle_limit   <= BusWidth'(7680);
         limits_ff.discharge_limit   <= ShuntWidth'(600);
         gain1_ff <= GainWidth'(31014);
         gain2_ff <= GainWidth'(67479);
         gain3_ff <= GainWidth'(85375);
      end else if (csr_we) begin
         case (reg_index_type'(csr_index))
            REG_OVERCURRENT: limits_ff.overcurrent_limit <= csr_wdata[ShuntWidth-1:0];
            REG_OVERVOLTAGE: limits_ff.overvoltage_limit <= csr_wdata[BusWidth-1:0];
            REG_UVLO_LOAD:   limits_ff.uvlo_load_limit   <= csr_wdata[BusWidth-1:0];
            REG_UVLO_IDLE:   limits_ff.uvlo_idle_limit   <= csr_wdata[BusWidth-1:0];
            REG_DISCHARGE:   limits_ff.discharge_limit   <= csr_wdata[ShuntWidth-1:0];
            REG_TAP1_GAIN:   gain1_ff <= csr_wdata[GainWidth-1:0];
            REG_TAP2_GAIN:   gain2_ff <= csr_wdata[GainWidth-1:0];
            REG_TAP3_GAIN:   gain3_ff <= csr_wdata[GainWidth-1:0];
            default: ;
         endcase
      end
   end

   logic v1_ff, v2_ff, v3_ff;
   logic rdy1, rdy2, rdy3;

   assign rdy3      = !v3_ff || rsp_ready;
   assign rdy2      = !v2_ff || rdy3;
   assign rdy1      = !v1_ff || rdy2;
   assign req_ready = rdy1;

   trip_type trip_in;
   trip_type trip1_ff, trip2_ff, trip3_ff;

   bpp_trip_eval u_trip (
      .limits     (limits_ff),
      .bus_code   (req_bus_code),
      .shunt_code (req_shunt_code),
      .trip       (trip_in)
   );

   logic [QWidth-1:0] t1_in, t2_in, t3_in;
   logic [QWidth-1:0] t1_ff, t2_ff, t3_ff;
   logic [QWidth-1:0] c1_ff, c2_ff, c3_ff;
   logic [QWidth-1:0] c2_in, c3_in;

   assign t1_in = QWidth'(req_tap1_sum) * QWidth'(gain1_ff);
   assign t2_in = QWidth'(req_tap2_sum) * QWidth'(gain2_ff);
   assign t3_in = QWidth'(req_tap3_sum) * QWidth'(gain3_ff);

   assign c2_in = (t2_ff > t1_ff) ? t2_ff - t1_ff : '0;
   assign c3_in = (t3_ff > t2_ff) ? t3_ff - t2_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
      end
   end

   logic bal1_ff, bal2_ff, bal3_ff;

   always_ff @(posedge clock) begin
      if (rdy1 && req_valid) begin
         t1_ff    <= t1_in;
         t2_ff    <= t2_in;
         t3_ff    <= t3_in;
         trip1_ff <= trip_in;
      end
      if (rdy2 && v1_ff) begin
         c1_ff    <= t1_ff;
         c2_ff    <= c2_in;
         c3_ff    <= c3_in;
         trip2_ff <= trip1_ff;
      end
      if (rdy3 && v2_ff) begin
         trip3_ff     <= trip2_ff;
         bal1_ff      <= (c1_ff > BalanceQ) && !trip2_ff.discharging;
         bal2_ff      <= (c2_ff > BalanceQ) && !trip2_ff.discharging;
         bal3_ff      <= (c3_ff > BalanceQ) && !trip2_ff.discharging;
         rsp_cell1_mv <= c1_ff[QWidth-1 -: MvWidth];
         rsp_cell2_mv <= c2_ff[QWidth-1 -: MvWidth];
         rsp_cell3_mv <= c3_ff[QWidth-1 -: MvWidth];
      end
   end

   assign rsp_valid         = v3_ff;
   assign rsp_trip_cause    = trip3_ff.cause;
   assign rsp_relay_closed  = (trip3_ff.cause == CAUSE_NONE);
   assign rsp_discharging   = trip3_ff.discharging;
   assign rsp_balance_one   = bal1_ff;
   assign rsp_balance_two   = bal2_ff;
   assign rsp_balance_three = bal3_ff;

endmodule

@@ rtl/bpp_checker.sv @@
module bpp_checker
   import bpp_pkg::*;
(
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic [BusWidth-1:0]           req_bus_code,
   input logic signed [ShuntWidth-1:0]  req_shunt_code,
   input logic [TapWidth-1:0]           req_tap1_sum,
   input logic [TapWidth-1:0]           req_tap2_sum,
   input logic [TapWidth-1:0]           req_tap3_sum,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          rsp_relay_closed,
   input logic [1:0]                    rsp_trip_cause,
   input logic                          rsp_discharging,
   input logic                          rsp_balance_one,
   input logic                          rsp_balance_two,
   input logic                          rsp_balance_three,
   input logic [MvWidth-1:0]            rsp_cell1_mv,
   input logic [MvWidth-1:0]            rsp_cell2_mv,
   input logic [MvWidth-1:0]            rsp_cell3_mv,
   input logic                          csr_we,
   input logic [CsrIdxWidth-1:0]        csr_index,
   input logic [CsrWidth-1:0]           csr_wdata
);

   a_relay_matches_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_relay_closed == (rsp_trip_cause == CAUSE_NONE)))
      else $error("relay state disagrees with trip cause");

   a_no_balance_discharging: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_discharging |->
         !rsp_balance_one && !rsp_balance_two && !rsp_balance_three)
      else $error("bleed switch on while discharging");

   a_balance_needs_voltage: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_balance_one |-> rsp_cell1_mv >= MvWidth'(4150))
      else $error("cell one balanced below threshold");

   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_trip_cause)
         && $stable(rsp_cell1_mv) && $stable(rsp_cell2_mv) && $stable(rsp_cell3_mv))
      else $error("stalled transfer changed");

   a_first_result_latency: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && $past(!req_valid, 1) && $past(!req_valid, 2)
         && $past(!req_valid, 3) && !$past(reset, 3) |=> !rsp_valid)
      else $error("result without matching input transfer");

endmodule

bind battery_pack_protection_unit bpp_checker u_bpp_checker (.*);
